// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/dnc_pkg.sv
`default_nettype none

package dnc_pkg;

  localparam int MAX_DIGITS = 16;
  localparam int MANT_W     = 64;
  localparam int EXP_W      = 9;
  localparam int CNT_W      = 5;
  localparam int CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic signed [EXP_W-1:0] EXP_MAX = 9'sd128;
  localparam logic signed [EXP_W-1:0] EXP_MIN = -9'sd128;

  localparam logic [CNT_W-1:0] SIG_DIGITS_RESET = 5'd4;

  typedef enum logic [1:0] {
    MODE_INT_ZEROS   = 2'd0,
    MODE_FRAC_ZEROS  = 2'd1,
    MODE_INT_DIGITS  = 2'd2,
    MODE_FRAC_DIGITS = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_t;

  typedef struct packed {
    logic valid;
    logic last;
  } step_t;

  typedef struct packed {
    logic [MANT_W-1:0]       mantissa;
    logic signed [EXP_W-1:0] exponent;
  } number_t;

  function automatic logic [CNT_W-1:0] digit_limit(input logic [CNT_W-1:0] sig);
    logic [CNT_W-1:0] lim;
    lim = sig;
    if (sig == '0) begin
      lim = CNT_W'(1);
    end else if (sig > CNT_W'(MAX_DIGITS)) begin
      lim = CNT_W'(MAX_DIGITS);
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dnc_char_if.sv
`default_nettype none

interface dnc_char_if import dnc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dnc_result_if.sv
`default_nettype none

interface dnc_result_if import dnc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MANT_W-1:0]       mantissa_a;
  logic [MANT_W-1:0]       mantissa_b;
  logic signed [EXP_W-1:0] exponent_a;
  logic signed [EXP_W-1:0] exponent_b;
  logic                    equal;

  modport source (output valid, output mantissa_a, output mantissa_b, output exponent_a,
                  output exponent_b, output equal, input ready);
  modport sink (input valid, input mantissa_a, input mantissa_b, input exponent_a,
                input exponent_b, input equal, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dnc_scanner.sv
`default_nettype none

module dnc_scanner import dnc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  char_t            cur,
  input  logic [CNT_W-1:0] sig_digits,
  output number_t          number
);

  scan_mode_t              mode;
  scan_mode_t              mode_next;
  logic signed [EXP_W-1:0] exp_acc;
  logic signed [EXP_W-1:0] exp_acc_next;
  logic [CNT_W-1:0]        taken;
  logic [CNT_W-1:0]        taken_next;
  logic [MANT_W-1:0]       mant;
  logic [MANT_W-1:0]       mant_next;
  logic                    take;
  logic                    is_digit;
  logic [3:0]              dig;
  logic [CHAR_W-1:0]       offset;

  assign is_digit = (cur.code >= CH_ZERO) && (cur.code <= CH_NINE);
  assign offset   = cur.code - CH_ZERO;
  assign dig      = offset[3:0];

  always_comb begin
    mode_next    = mode;
    exp_acc_next = exp_acc;
    taken_next   = taken;
    mant_next    = mant;
    take         = 1'b0;
    if (cur.code == CH_POINT) begin
      unique case (mode)
        MODE_INT_ZEROS:  mode_next = MODE_FRAC_ZEROS;
        MODE_INT_DIGITS: mode_next = MODE_FRAC_DIGITS;
        default: ;
      endcase
    end else if (is_digit) begin
      unique case (mode)
        MODE_INT_ZEROS: begin
          if (dig != 4'd0) begin
            mode_next = MODE_INT_DIGITS;
            take      = 1'b1;
            if (exp_acc < EXP_MAX) begin
              exp_acc_next = exp_acc + 9'sd1;
            end
          end
        end
        MODE_FRAC_ZEROS: begin
          if (dig == 4'd0) begin
            if (exp_acc > EXP_MIN) begin
              exp_acc_next = exp_acc - 9'sd1;
            end
          end else begin
            mode_next = MODE_FRAC_DIGITS;
            take      = 1'b1;
          end
        end
        MODE_INT_DIGITS: begin
          take = 1'b1;
          if (exp_acc < EXP_MAX) begin
            exp_acc_next = exp_acc + 9'sd1;
          end
        end
        default: begin
          take = 1'b1;
        end
      endcase
    end

    // The new digit goes into the nibble just below those already taken.
    if (take && (taken < digit_limit(sig_digits))) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (taken == CNT_W'(i)) begin
          mant_next[MANT_W-4-4*i +: 4] = dig;
        end
      end
      taken_next = taken + CNT_W'(1);
    end

    if ((mode_next == MODE_INT_DIGITS) || (mode_next == MODE_FRAC_DIGITS)) begin
      number.mantissa = mant_next;
      number.exponent = exp_acc_next;
    end else begin
      number.mantissa = '0;
      number.exponent = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_INT_ZEROS;
      exp_acc <= '0;
      taken   <= '0;
      mant    <= '0;
    end else if (step) begin
      if (cur.last) begin
        mode    <= MODE_INT_ZEROS;
        exp_acc <= '0;
        taken   <= '0;
        mant    <= '0;
      end else begin
        mode    <= mode_next;
        exp_acc <= exp_acc_next;
        taken   <= taken_next;
        mant    <= mant_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dnc_pair.sv
`default_nettype none

module dnc_pair import dnc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  step_t   req,
  input  number_t number,
  output logic    advance,
  dnc_result_if.source out_ch
);

  logic                    second_operand;
  logic [MANT_W-1:0]       held_mantissa;
  logic signed [EXP_W-1:0] held_exponent;
  logic                    out_valid;
  logic                    finish;
  logic                    emit;

  assign finish  = req.valid && req.last;
  assign emit    = finish && second_operand;
  assign advance = !emit || !out_valid || out_ch.ready;

  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_operand <= 1'b0;
      held_mantissa  <= '0;
      held_exponent  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (finish && advance) begin
        if (!second_operand) begin
          held_mantissa  <= number.mantissa;
          held_exponent  <= number.exponent;
          second_operand <= 1'b1;
        end else begin
          second_operand <= 1'b0;
        end
      end
      if (emit && advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit && advance) begin
      out_ch.mantissa_a <= held_mantissa;
      out_ch.mantissa_b <= number.mantissa;
      out_ch.exponent_a <= held_exponent;
      out_ch.exponent_b <= number.exponent;
      out_ch.equal      <= (held_mantissa == number.mantissa) &&
                           (held_exponent == number.exponent);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/decimal_normalize_compare_unit.sv
// Timing: the final character of the second number is taken into the input register when
// accepted, and the result register loads when that character steps out of the input register.
// Throughput: one character per cycle; input stalls only while a result waits unaccepted
// in the result register and the input register holds the end of the next second number.
// Reset: sig_digits returns to 4, the scan state, held first number and result valid clear.
`default_nettype none

module decimal_normalize_compare_unit import dnc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  dnc_char_if.sink         in_ch,
  dnc_result_if.source     out_ch
);

  logic [CNT_W-1:0] sig_digits;
  logic             s1_valid;
  char_t            s1_char;
  logic             advance;
  logic             step;
  step_t            req;
  number_t          number;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_digits <= SIG_DIGITS_RESET;
    end else if (cfg_wr_en) begin
      sig_digits <= cfg_wr_data;
    end
  end

  assign in_ch.ready = !s1_valid || advance;
  assign step        = s1_valid && advance;
  assign req.valid   = s1_valid;
  assign req.last    = s1_char.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char.code <= in_ch.char_code;
      s1_char.last <= in_ch.last_char;
    end
  end

  dnc_scanner u_scanner (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .cur        (s1_char),
    .sig_digits (sig_digits),
    .number     (number)
  );

  dnc_pair u_pair (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .number  (number),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// File: rtl/core/dnc_checker.sv
`default_nettype none

`include "assert_macros.svh"

module dnc_checker import dnc_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [MANT_W-1:0]       mant_a,
  input logic [MANT_W-1:0]       mant_b,
  input logic signed [EXP_W-1:0] exp_a,
  input logic signed [EXP_W-1:0] exp_b,
  input logic                    equal
);

  `ASSERT_CLK(a_reset_clears, clk, rst |=> !out_valid, "result valid after reset")

  `ASSERT_CLK_RST(a_hold_payload, clk, rst, out_valid && !out_ready |=> out_valid && $stable(mant_a) && $stable(mant_b) && $stable(exp_a) && $stable(exp_b) && $stable(equal), "stalled result changed")

  `ASSERT_CLK_RST(a_equal_flag, clk, rst, out_valid |-> (equal == ((mant_a == mant_b) && (exp_a == exp_b))), "equal flag disagrees with fields")

  `ASSERT_CLK_RST(a_zero_a, clk, rst, out_valid && (mant_a == '0) |-> (exp_a == '0), "zero first number has nonzero exponent")

  `ASSERT_CLK_RST(a_zero_b, clk, rst, out_valid && (mant_b == '0) |-> (exp_b == '0), "zero second number has nonzero exponent")

endmodule

bind decimal_normalize_compare_unit dnc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .mant_a    (out_ch.mantissa_a),
  .mant_b    (out_ch.mantissa_b),
  .exp_a     (out_ch.exponent_a),
  .exp_b     (out_ch.exponent_b),
  .equal     (out_ch.equal)
);

`default_nettype wire
